@@ hdl/sha256_block_compress_core_defines.svh @@
// Assertion macros for the checker file of the SHA-256 compression core.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef SHA256_BLOCK_COMPRESS_CORE_DEFINES_SVH
`define SHA256_BLOCK_COMPRESS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA256BC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA256BC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sha256bc_pkg.sv @@
`default_nettype none

package sha256bc_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned WIN_LEN  = 16;
   localparam int unsigned NUM_HASH = 8;
   localparam int unsigned ROUNDS   = 64;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [31:0] msg_word;
      logic        first_block;
      logic        final_block;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Controls from the sequencer to the schedule window.
   typedef struct packed {
      logic load_word;
      logic expand;
   } sched_ctl_type;

   // Controls from the sequencer to the round datapath.
   typedef struct packed {
      logic load;
      logic use_iv;
      logic round;
      logic fold;
   } round_ctl_type;

   localparam word_type INIT_HASH [NUM_HASH] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type choose(input word_type e, input word_type f,
                                       input word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(input word_type a, input word_type b,
                                         input word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

`default_nettype wire

@@ hdl/sha256bc_sched.sv @@
`default_nettype none

// Sixteen-word message schedule window. Words shift in at the top; during
// compression each step retires W[t] and appends W[t+16].
module sha256bc_sched
   import sha256bc_pkg::*;
(
   input  wire logic          clock,
   input  wire sched_ctl_type ctl,
   input  wire word_type      msg_word,
   output      word_type      w_cur
);

   word_type win_ff [WIN_LEN];
   word_type new_word;

   always_comb begin
      if (ctl.load_word) begin
         new_word = msg_word;
      end else begin
         new_word = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9]
                    + small_sigma1(win_ff[14]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_word || ctl.expand) begin
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WIN_LEN-1] <= new_word;
      end
   end

   assign w_cur = win_ff[0];

endmodule

`default_nettype wire

@@ hdl/sha256bc_round.sv @@
`default_nettype none

// Working variables, one SHA-256 round per cycle, and the chaining value.
module sha256bc_round
   import sha256bc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire round_ctl_type ctl,
   input  wire word_type      k_cur,
   input  wire word_type      w_cur,
   input  wire logic [2:0]    rd_index,
   output      word_type      rd_word
);

   word_type work_ff  [NUM_HASH];
   word_type chain_ff [NUM_HASH];
   word_type t1;
   word_type t2;

   always_comb begin
      t1 = work_ff[7] + big_sigma1(work_ff[4])
           + choose(work_ff[4], work_ff[5], work_ff[6]) + k_cur + w_cur;
      t2 = big_sigma0(work_ff[0]) + majority(work_ff[0], work_ff[1], work_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            work_ff[i] <= ctl.use_iv ? INIT_HASH[i] : chain_ff[i];
         end
      end else if (ctl.round) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            chain_ff[i] <= INIT_HASH[i];
         end
      end else if (ctl.load && ctl.use_iv) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            chain_ff[i] <= INIT_HASH[i];
         end
      end else if (ctl.fold) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            chain_ff[i] <= chain_ff[i] + work_ff[i];
         end
      end
   end

   assign rd_word = chain_ff[rd_index];

endmodule

`default_nettype wire

@@ hdl/sha256_block_compress_core.sv @@
`default_nettype none

// Channel   Direction  Ports                               Carries
// request   in         req_valid, req_ready, req_payload   one message word and block flags
// response  out        rsp_valid, rsp_ready, rsp_payload   one digest word with its index
//
// A message word is taken whenever the core is idle. The word that completes a
// block starts the compression rounds on the round unit, followed by a fold step
// that adds the working variables into the chaining value. After a final block
// the eight digest words follow, one per cycle while rsp_ready is high.
// Reset restores the standard initial hash value and clears the sequencer.
module sha256_block_compress_core
   import sha256bc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_payload,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_payload
);

   // The sequencer states use one-hot codes.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FOLD  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [3:0]    word_cnt_ff, word_cnt_in;
   logic [5:0]    round_cnt_ff, round_cnt_in;
   logic [2:0]    out_cnt_ff, out_cnt_in;
   logic          final_ff, final_in;

   logic          req_fire;
   logic          rsp_fire;
   sched_ctl_type sched_ctl;
   round_ctl_type round_ctl;
   word_type      w_cur;
   word_type      rd_word;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // The sequencer walks a block through word loading, the round loop, the
   // fold into the chaining value and, for a final block, the digest output.
   always_comb begin
      state_in     = state_ff;
      word_cnt_in  = word_cnt_ff;
      round_cnt_in = round_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      final_in     = final_ff;
      sched_ctl    = '0;
      round_ctl    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sched_ctl.load_word = 1'b1;
               word_cnt_in         = word_cnt_ff + 4'd1;
               // The flags only count on the word that completes the block.
               if (word_cnt_ff == 4'(WIN_LEN - 1)) begin
                  round_ctl.load   = 1'b1;
                  round_ctl.use_iv = req_payload.first_block;
                  final_in         = req_payload.final_block;
                  round_cnt_in     = '0;
                  state_in         = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            round_ctl.round = 1'b1;
            sched_ctl.expand = 1'b1;
            round_cnt_in    = round_cnt_ff + 6'd1;
            if (round_cnt_ff == 6'(ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            round_ctl.fold = 1'b1;
            out_cnt_in     = '0;
            state_in       = final_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               out_cnt_in = out_cnt_ff + 3'd1;
               if (out_cnt_ff == 3'(NUM_HASH - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word_cnt_ff  <= '0;
         round_cnt_ff <= '0;
         out_cnt_ff   <= '0;
         final_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_cnt_ff  <= word_cnt_in;
         round_cnt_ff <= round_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         final_ff     <= final_in;
      end
   end

   sha256bc_sched u_sched (
      .clock    (clock),
      .ctl      (sched_ctl),
      .msg_word (req_payload.msg_word),
      .w_cur    (w_cur)
   );

   sha256bc_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctl      (round_ctl),
      .k_cur    (ROUND_K[round_cnt_ff]),
      .w_cur    (w_cur),
      .rd_index (out_cnt_ff),
      .rd_word  (rd_word)
   );

   // The digest words come straight from the chaining registers, which hold
   // still while the core is in the output state.
   assign rsp_payload.digest_word = rd_word;
   assign rsp_payload.word_index  = out_cnt_ff;
   assign rsp_payload.last_word   = (out_cnt_ff == 3'(NUM_HASH - 1));

endmodule

`default_nettype wire

@@ hdl/sha256bc_checker.sv @@
`default_nettype none

`include "sha256_block_compress_core_defines.svh"

module sha256bc_checker
   import sha256bc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);

   logic rsp_fire;
   assign rsp_fire = rsp_valid && rsp_ready;

   `SHA256BC_ASSERT_NOW(a_no_req_during_rsp, rsp_valid, !req_ready, "request taken while digest pending")
   `SHA256BC_ASSERT_NOW(a_last_matches_index, rsp_valid, rsp_payload.last_word == (rsp_payload.word_index == 3'd7), "last_word does not match word_index")
   `SHA256BC_ASSERT_NEXT(a_index_advances, rsp_fire && !rsp_payload.last_word, rsp_valid && (rsp_payload.word_index == $past(rsp_payload.word_index) + 3'd1), "digest words out of order")
   `SHA256BC_ASSERT_NEXT(a_stop_after_last, rsp_fire && rsp_payload.last_word, !rsp_valid, "digest word after the last one")
   `SHA256BC_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled response changed")

endmodule

bind sha256_block_compress_core sha256bc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
